// ----- hdl/srnt_pkg.sv -----
package srnt_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int AW           = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = AW + 1;

  localparam int CFG_W        = 7;
  localparam int IDX_W        = 6;
  localparam int KIND_W       = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 8;

  localparam logic OP_ARRIVE  = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RANGE    = 2'd2;

endpackage

// ----- hdl/srnt_ram.sv -----
module srnt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/segment_reassembly_nack_tracker.sv -----
// Arrival beat: after the write, the lowest-missing pointer climbs past received indices,
//   one bitmap read and check per index, stopping at MAX_SEGMENTS at most.
// Timeout beat: sweeps the bitmap from the lowest missing index up to the highest
//   seen; out_tready low holds the sweep. A completion after other results is its own beat.
// Reset (rst_n low, synchronous): clears control state, then a clearing pass zeroes
//   every bitmap entry with in_tready held low. One item at a time.
module segment_reassembly_nack_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [srnt_pkg::CFG_W-1:0]          cfg_wr_data,    // segment_count
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [srnt_pkg::IN_TDATA_W-1:0]     in_tdata,       // [5:0] segment_index
  input  logic                                in_tuser,       // [0] opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [srnt_pkg::OUT_TDATA_W-1:0]    out_tdata,      // [5:0] missing_index
  output logic [srnt_pkg::KIND_W-1:0]         out_tuser,      // [1:0] result_kind
  output logic                                out_tlast       // last_of_run
);

  localparam logic [2:0] S_CLR      = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CHK = 3'd3;
  localparam logic [2:0] S_SW_RD    = 3'd4;
  localparam logic [2:0] S_SW_CHK   = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  localparam int AW    = srnt_pkg::AW;
  localparam int CNT_W = srnt_pkg::CNT_W;
  localparam int CFG_W = srnt_pkg::CFG_W;

  logic [2:0]                   state_r, state_nxt;
  logic [CFG_W-1:0]             cfg_count_r;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic [CNT_W-1:0]             low_r, low_nxt;
  logic [AW-1:0]                high_r, high_nxt;
  logic [AW-1:0]                sweep_r, sweep_nxt;
  logic                         done_r, done_nxt;
  logic                         pend_r, pend_nxt;
  logic [srnt_pkg::KIND_W-1:0]  pend_kind_r, pend_kind_nxt;
  logic [AW-1:0]                pend_idx_r, pend_idx_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [srnt_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [AW-1:0]                out_idx_r, out_idx_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [CNT_W-1:0]             eff_count;
  logic                         complete;
  logic                         out_free;
  logic                         in_fire;
  logic [AW-1:0]                in_idx;
  logic                         in_range;
  logic [CNT_W-1:0]             low_inc;
  logic [CNT_W-1:0]             sweep_inc;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic                         mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic                         mem_rdata;

  srnt_ram #(
    .WIDTH (1),
    .DEPTH (srnt_pkg::MAX_SEGMENTS)
  ) u_map (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign eff_count = (cfg_count_r > CFG_W'(srnt_pkg::MAX_SEGMENTS)) ?
                     CNT_W'(srnt_pkg::MAX_SEGMENTS) : CNT_W'(cfg_count_r);
  assign complete  = (low_r >= eff_count);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_idx    = in_tdata[AW-1:0];
  assign in_range  = (CFG_W'(in_tdata[srnt_pkg::IDX_W-1:0]) < CFG_W'(eff_count));
  assign low_inc   = low_r + CNT_W'(1);
  assign sweep_inc = {1'b0, sweep_r} + CNT_W'(1);

  assign mem_re    = (state_r == S_SCAN_RD) || (state_r == S_SW_RD);
  assign mem_raddr = (state_r == S_SW_RD) ? sweep_r : low_r[AW-1:0];

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = srnt_pkg::OUT_TDATA_W'(out_idx_r);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    sweep_nxt     = sweep_r;
    done_nxt      = done_r;
    pend_nxt      = pend_r;
    pend_kind_nxt = pend_kind_r;
    pend_idx_nxt  = pend_idx_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_CLR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(srnt_pkg::MAX_SEGMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire && !done_r) begin
          if (in_tuser == srnt_pkg::OP_ARRIVE) begin
            if (!in_range) begin
              pend_nxt      = 1'b1;
              pend_kind_nxt = srnt_pkg::KIND_RANGE;
              pend_idx_nxt  = '0;
              state_nxt     = S_FIN;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = in_idx;
              mem_wdata = 1'b1;
              if (in_idx > high_r) begin
                high_nxt = in_idx;
              end
              if ({1'b0, in_idx} == low_r) begin
                low_nxt = low_inc;
                if (low_inc == CNT_W'(srnt_pkg::MAX_SEGMENTS)) begin
                  state_nxt = S_FIN;
                end else begin
                  state_nxt = S_SCAN_RD;
                end
              end else begin
                state_nxt = S_FIN;
              end
            end
          end else begin
            if (low_r >= {1'b0, high_r}) begin
              state_nxt = S_FIN;
            end else begin
              sweep_nxt = low_r[AW-1:0];
              state_nxt = S_SW_RD;
            end
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (mem_rdata) begin
          low_nxt = low_inc;
          if (low_inc == CNT_W'(srnt_pkg::MAX_SEGMENTS)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SW_RD: begin
        state_nxt = S_SW_CHK;
      end
      S_SW_CHK: begin
        if (!mem_rdata && pend_r && !out_free) begin
          state_nxt = S_SW_CHK;
        end else begin
          if (!mem_rdata) begin
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_idx_nxt   = pend_idx_r;
              out_last_nxt  = 1'b0;
            end
            pend_nxt      = 1'b1;
            pend_kind_nxt = srnt_pkg::KIND_REQUEST;
            pend_idx_nxt  = sweep_r;
          end
          sweep_nxt = sweep_inc[AW-1:0];
          if (sweep_inc == {1'b0, high_r}) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SW_RD;
          end
        end
      end
      S_FIN: begin
        if (pend_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = pend_kind_r;
            out_idx_nxt   = pend_idx_r;
            out_last_nxt  = !complete;
            pend_nxt      = 1'b0;
            if (!complete) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (complete) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = srnt_pkg::KIND_COMPLETE;
            out_idx_nxt   = '0;
            out_last_nxt  = 1'b1;
            done_nxt      = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cfg_count_r <= CFG_W'(1);
      clr_r       <= '0;
      low_r       <= '0;
      high_r      <= '0;
      sweep_r     <= '0;
      done_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      sweep_r     <= sweep_nxt;
      done_r      <= done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_kind_r  <= out_kind_nxt;
    out_idx_r   <= out_idx_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ----- hdl/srnt_checker.sv -----
module srnt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [srnt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [srnt_pkg::KIND_W-1:0]       out_tuser,
  input logic                              out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("out beat changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == srnt_pkg::KIND_REQUEST) ||
                   (out_tuser == srnt_pkg::KIND_COMPLETE) ||
                   (out_tuser == srnt_pkg::KIND_RANGE))
    else $error("illegal result kind");

  a_complete_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == srnt_pkg::KIND_COMPLETE) |-> out_tlast && (out_tdata == '0))
    else $error("completion beat not last or index nonzero");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tuser == srnt_pkg::KIND_COMPLETE) |=> !out_tvalid)
    else $error("result beat after transfer completion");

endmodule

bind segment_reassembly_nack_tracker srnt_checker u_srnt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/segment_tracker_checker.sv -----
`timescale 1ns / 100ps

module segment_tracker_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [srnt_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [srnt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [srnt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [srnt_pkg::KIND_W-1:0]      out_tuser,
  input  logic                             out_tlast,
  output int                               fail_count,
  output int                               pending
);

  import srnt_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } reply_t;

  reply_t                reply_q[$];
  logic [CFG_W-1:0]      seg_cnt;
  logic [MAX_SEGMENTS-1:0] rcv_map;
  logic [IDX_W-1:0]      top_idx;
  logic                  xfer_done;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned needed_count();
    return (seg_cnt > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_cnt;
  endfunction

  task automatic track_item(input logic op, input logic [IDX_W-1:0] idx);
    reply_t          r;
    reply_t          run_q[$];
    int unsigned     n;
    logic [MAX_SEGMENTS-1:0] need;
    n = needed_count();
    if (xfer_done) return;
    if (op == OP_ARRIVE) begin
      if (idx >= n) begin
        r = '{kind: KIND_RANGE, idx: '0, last: 1'b0};
        run_q.push_back(r);
      end else begin
        if (idx > top_idx) top_idx = idx;
        rcv_map[idx] = 1'b1;
      end
    end else begin
      for (int i = 0; i < top_idx; i++) begin
        if (!rcv_map[i]) begin
          r = '{kind: KIND_REQUEST, idx: IDX_W'(i), last: 1'b0};
          run_q.push_back(r);
        end
      end
    end
    if (n >= MAX_SEGMENTS) need = '1;
    else need = (MAX_SEGMENTS'(1) << n) - 1'b1;
    if ((rcv_map & need) == need) begin
      xfer_done = 1'b1;
      r = '{kind: KIND_COMPLETE, idx: '0, last: 1'b0};
      run_q.push_back(r);
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[k]) reply_q.push_back(run_q[k]);
  endtask

  always @(posedge clk) begin : watch
    reply_t r;
    if (!rst_n) begin
      seg_cnt   = CFG_W'(1);
      rcv_map   = '0;
      top_idx   = '0;
      xfer_done = 1'b0;
      reply_q.delete();
    end else begin
      if (cfg_wr_en) seg_cnt = cfg_wr_data;
      if (in_tvalid && in_tready) track_item(in_tuser, in_tdata[IDX_W-1:0]);
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          $error("result beat with nothing expected: result_kind %0d missing_index %0d",
                 out_tuser, out_tdata[IDX_W-1:0]);
          fail_count++;
        end else begin
          r = reply_q.pop_front();
          if (out_tuser !== r.kind) begin
            $error("result_kind expected %0d got %0d", r.kind, out_tuser);
            fail_count++;
          end
          if (out_tdata[IDX_W-1:0] !== r.idx) begin
            $error("missing_index expected %0d got %0d", r.idx, out_tdata[IDX_W-1:0]);
            fail_count++;
          end
          if (out_tlast !== r.last) begin
            $error("last_of_run expected %0d got %0d", r.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = reply_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  import srnt_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 1500;
  localparam int IDLE_LIMIT    = 20000;
  localparam int BATCHES       = 12;
  localparam int BATCH_ITEMS   = 28;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [CFG_W-1:0]        cfg_wr_data;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [KIND_W-1:0]       out_tuser;
  logic                    out_tlast;

  int fail_count;
  int pending;
  int idle_cycles;
  bit hold_req;

  segment_reassembly_nack_tracker u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  segment_tracker_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : sink
    int r;
    int k;
    logic v;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(99);
        if (r < 50) begin
          v = 1'b1;
          k = $urandom_range(1, 20);
        end else if (r < 90) begin
          v = 1'b0;
          k = $urandom_range(1, 3);
        end else begin
          v = 1'b0;
          k = $urandom_range(10, 60);
        end
        out_tready <= v;
        repeat (k) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx);
    int r;
    int gap;
    r = $urandom_range(99);
    if (r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W-IDX_W){1'b0}}, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int r;
    int hi;
    int start;
    logic [CFG_W-1:0] cnt;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_ARRIVE;
    idle_cycles = 0;
    hold_req    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // count of one after reset: sweep with nothing seen, range errors
    send_beat(OP_TIMEOUT, 6'd0);
    send_beat(OP_ARRIVE, 6'd63);
    send_beat(OP_ARRIVE, 6'd1);
    drain_block();

    // saturating count, wide sweep
    write_count(7'd127);
    send_beat(OP_ARRIVE, 6'd63);
    send_beat(OP_ARRIVE, 6'd1);
    send_beat(OP_ARRIVE, 6'd62);
    send_beat(OP_ARRIVE, 6'd32);
    send_beat(OP_TIMEOUT, 6'd63);
    drain_block();

    write_count(7'd65);
    send_beat(OP_ARRIVE, 6'd30);
    send_beat(OP_TIMEOUT, 6'd21);
    drain_block();

    // lowered count: sweep still runs below the highest index seen
    write_count(7'd5);
    send_beat(OP_ARRIVE, 6'd5);
    send_beat(OP_ARRIVE, 6'd63);
    send_beat(OP_ARRIVE, 6'd4);
    send_beat(OP_TIMEOUT, 6'd42);
    drain_block();

    // hold segment zero back so the transfer stays open
    for (int b = 0; b < BATCHES; b++) begin
      case ($urandom_range(4))
        0:       cnt = 7'd127;
        1:       cnt = 7'd64;
        2:       cnt = 7'd65;
        3:       cnt = CFG_W'($urandom_range(1, 64));
        default: cnt = CFG_W'($urandom_range(1, 12));
      endcase
      write_count(cnt);
      hi = (6 + b * 5 > 63) ? 63 : 6 + b * 5;
      if (b == 2) begin
        hold_req = 1'b1;
        send_beat(OP_TIMEOUT, IDX_W'($urandom));
      end
      for (int i = 0; i < BATCH_ITEMS; i++) begin
        r = $urandom_range(99);
        if (r < 10) send_beat(OP_TIMEOUT, IDX_W'($urandom));
        else if (r < 25) send_beat(OP_ARRIVE, IDX_W'($urandom_range(1, 63)));
        else send_beat(OP_ARRIVE, IDX_W'($urandom_range(1, hi)));
      end
      drain_block();
    end

    if ($urandom_range(1)) begin
      write_count(7'd64);
      start = $urandom_range(0, 62);
      for (int i = 0; i < 63; i++) send_beat(OP_ARRIVE, IDX_W'(1 + (start + i) % 63));
      send_beat(OP_TIMEOUT, 6'd0);
      send_beat(OP_ARRIVE, 6'd0);
    end else begin
      // zero count completes on the next beat
      write_count(7'd0);
      send_beat(logic'($urandom_range(1)), IDX_W'($urandom));
      for (int i = 0; i < 63; i++) send_beat(logic'($urandom_range(1)), IDX_W'($urandom));
    end

    // done: further beats are dropped
    send_beat(OP_TIMEOUT, 6'd0);
    send_beat(OP_ARRIVE, 6'd63);
    send_beat(OP_ARRIVE, 6'd0);
    drain_block();

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/srnt_pkg.sv
hdl/srnt_ram.sv
hdl/segment_reassembly_nack_tracker.sv
hdl/srnt_checker.sv
tb/segment_tracker_checker.sv
tb/testbench.sv
